FILE: rtl/ssl_pkg.sv
`timescale 1ns / 1ps

package ssl_pkg;

    // Width of the millisecond time base kept in state; timestamps wrap at 2^TIME_BITS.
    localparam int TIME_BITS = 32;

    localparam int ANGLE_BITS = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [ANGLE_BITS-1:0] ANGLE_MIN = 8'd0;
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 8'd180;
    localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = 8'd90;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_DEGREES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_DELAY = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_DEGREES = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] STEP_DEGREES_RESET = 8'd2;
    localparam logic [15:0] STEP_INTERVAL_RESET = 16'd20;
    localparam logic [15:0] RELEASE_DELAY_RESET = 16'd1000;
    localparam logic [7:0] CENTER_DEGREES_RESET = 8'd90;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_WRITE_NOW  = 2'd2,
        CMD_RELEASE    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [31:0]        now_ms;
        logic signed [15:0] angle;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] servo_angle;
        logic                  angle_written;
        logic                  attached;
        logic                  at_target;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  step_degrees;
        logic [15:0] step_interval_ms;
        logic [15:0] release_delay_ms;
        logic [7:0]  center_degrees;
    } t_cfg;

    // Saturate a signed request to the servo's 0..180 degree range.
    function automatic logic [ANGLE_BITS-1:0] clamp_angle(input logic signed [15:0] raw);
        logic [ANGLE_BITS-1:0] res;
        if (raw < 16'sd0) begin
            res = ANGLE_MIN;
        end else if (raw > 16'sd180) begin
            res = ANGLE_MAX;
        end else begin
            res = raw[ANGLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/servo_slew_limiter_auto_release.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------
// in       | input     | i_in_valid / o_in_stall   | i_in_item  (cmd, now, angle)
// out      | output    | o_out_valid / i_out_stall | o_out_item (angle, flags)
// cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item per clock while the output is not stalled; every item gives one result.
// The rate is set by the state update between the input and result registers.
// Reset is synchronous and active low; it restores the configuration and servo state.
// A stalled result holds the output register; o_in_stall rises only while an item waits
// in the input register and the output register cannot be loaded.

module servo_slew_limiter_auto_release (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ssl_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ssl_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [ssl_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ssl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic               r_in_valid;
    ssl_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    ssl_pkg::t_out_item r_out_item;

    ssl_pkg::t_cfg      cfg;
    ssl_pkg::t_out_item core_result;
    logic               out_can_load;
    logic               advance;

    // Pipeline flow control.
    assign out_can_load = !r_out_valid || !i_out_stall;
    assign advance      = r_in_valid && out_can_load;
    assign o_in_stall   = r_in_valid && !out_can_load;

    ssl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssl_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_can_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/ssl_cfg_regs.sv
`timescale 1ns / 1ps

module ssl_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ssl_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [ssl_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output ssl_pkg::t_cfg                        o_cfg
);

    ssl_pkg::t_cfg r_cfg;

    // Register file: each write lands in the register its index selects.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_degrees     <= ssl_pkg::STEP_DEGREES_RESET;
            r_cfg.step_interval_ms <= ssl_pkg::STEP_INTERVAL_RESET;
            r_cfg.release_delay_ms <= ssl_pkg::RELEASE_DELAY_RESET;
            r_cfg.center_degrees   <= ssl_pkg::CENTER_DEGREES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssl_pkg::CFG_STEP_DEGREES: begin
                    r_cfg.step_degrees <= i_cfg_data[7:0];
                end
                ssl_pkg::CFG_STEP_INTERVAL: begin
                    r_cfg.step_interval_ms <= i_cfg_data;
                end
                ssl_pkg::CFG_RELEASE_DELAY: begin
                    r_cfg.release_delay_ms <= i_cfg_data;
                end
                ssl_pkg::CFG_CENTER_DEGREES: begin
                    r_cfg.center_degrees <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/ssl_core.sv
`timescale 1ns / 1ps

module ssl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssl_pkg::t_cfg      i_cfg,
    input  logic               i_advance,
    input  ssl_pkg::t_in_item  i_item,
    output ssl_pkg::t_out_item o_result
);

    logic [ssl_pkg::ANGLE_BITS-1:0] r_cur;
    logic [ssl_pkg::ANGLE_BITS-1:0] r_tgt;
    ssl_pkg::t_time                 r_last;
    ssl_pkg::t_time                 r_dwell;
    logic                           r_en;

    logic [ssl_pkg::ANGLE_BITS-1:0] n_cur;
    logic [ssl_pkg::ANGLE_BITS-1:0] n_tgt;
    ssl_pkg::t_time                 n_last;
    ssl_pkg::t_time                 n_dwell;
    logic                           n_en;
    logic                           n_written;

    ssl_pkg::t_time                 now_t;
    ssl_pkg::t_time                 step_elapsed;
    ssl_pkg::t_time                 dwell_elapsed;
    ssl_pkg::t_time                 dwell_after_step;
    logic                           step_ok;
    logic [ssl_pkg::ANGLE_BITS:0]   up_sum;
    logic [ssl_pkg::ANGLE_BITS:0]   down_limit;
    logic [ssl_pkg::ANGLE_BITS-1:0] stepped;
    logic [ssl_pkg::ANGLE_BITS-1:0] req_angle;

    // Shared arithmetic: the clamped requested angle and, for the tick command, the elapsed times and the step result.
    always_comb begin
        now_t        = ssl_pkg::TIME_BITS'(i_item.now_ms);
        req_angle    = ssl_pkg::clamp_angle(i_item.angle);
        step_elapsed = now_t - r_last;
        step_ok      = r_en && (r_cur != r_tgt) &&
                       (step_elapsed >= ssl_pkg::TIME_BITS'(i_cfg.step_interval_ms));
        up_sum       = {1'b0, r_cur} + {1'b0, i_cfg.step_degrees};
        down_limit   = {1'b0, r_tgt} + {1'b0, i_cfg.step_degrees};
        if (r_cur < r_tgt) begin
            stepped = (up_sum < {1'b0, r_tgt}) ? up_sum[ssl_pkg::ANGLE_BITS-1:0] : r_tgt;
        end else if ({1'b0, r_cur} < down_limit) begin
            stepped = r_tgt;
        end else begin
            stepped = r_cur - i_cfg.step_degrees;
        end
        dwell_after_step = step_ok ? '0 : r_dwell;
        dwell_elapsed    = now_t - dwell_after_step;
    end

    // Command decode and next state.
    always_comb begin
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_last    = r_last;
        n_dwell   = r_dwell;
        n_en      = r_en;
        n_written = 1'b0;
        unique case (i_item.cmd)
            ssl_pkg::CMD_TICK: begin
                if (step_ok) begin
                    n_last    = now_t;
                    n_cur     = stepped;
                    n_written = 1'b1;
                end
                n_dwell = dwell_after_step;
                if (r_en && (n_cur == r_tgt)) begin
                    if (r_tgt == i_cfg.center_degrees) begin
                        if (dwell_after_step == '0) begin
                            n_dwell = now_t;
                        end else if (dwell_elapsed >=
                                     ssl_pkg::TIME_BITS'(i_cfg.release_delay_ms)) begin
                            n_en    = 1'b0;
                            n_dwell = '0;
                        end
                    end else begin
                        n_dwell = '0;
                    end
                end
            end
            ssl_pkg::CMD_SET_TARGET: begin
                n_tgt     = req_angle;
                n_dwell   = '0;
                n_en      = 1'b1;
                n_written = !r_en;
            end
            ssl_pkg::CMD_WRITE_NOW: begin
                n_cur     = req_angle;
                n_tgt     = req_angle;
                n_dwell   = '0;
                n_en      = 1'b1;
                n_written = 1'b1;
            end
            ssl_pkg::CMD_RELEASE: begin
                n_en    = 1'b0;
                n_dwell = '0;
            end
            default: begin
            end
        endcase
    end

    // State registers; they move only when an item passes to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= ssl_pkg::ANGLE_RESET;
            r_tgt   <= ssl_pkg::ANGLE_RESET;
            r_last  <= '0;
            r_dwell <= '0;
            r_en    <= 1'b0;
        end else if (i_advance) begin
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_last  <= n_last;
            r_dwell <= n_dwell;
            r_en    <= n_en;
        end
    end

    // Result of the item being processed, taken from the updated state.
    always_comb begin
        o_result.servo_angle   = n_cur;
        o_result.angle_written = n_written;
        o_result.attached      = n_en;
        o_result.at_target     = (n_cur == n_tgt);
    end

`ifndef SYNTHESIS
    // An immediate write always leaves the drive enabled and on target.
    a_write_now_on_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (i_item.cmd == ssl_pkg::CMD_WRITE_NOW)) |=> (r_en && (r_cur == r_tgt)))
        else $error("write immediately did not settle on target");

    // Angles never leave the servo range.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= ssl_pkg::ANGLE_MAX) && (r_tgt <= ssl_pkg::ANGLE_MAX))
        else $error("angle out of range");

    // Without an item the state holds.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_cur) && $stable(r_tgt) && $stable(r_en) && $stable(r_dwell)))
        else $error("state changed without an item");

    // A tick on a released drive neither moves the angle nor attaches.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (i_item.cmd == ssl_pkg::CMD_TICK) && !r_en) |=> (!r_en && $stable(r_cur)))
        else $error("tick moved a released servo");
`endif

endmodule
